/* src/aph_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aph_pkg
// Shared constants and types for the activity priority heap.
// ----------------------------------------------------------------------------
package aph_pkg;
  localparam int VarCount = 128;
  localparam int VarW = 8;
  localparam int SlotW = 7;
  localparam int CntW = 8;
  localparam logic [63:0] ScoreLimit = 64'd18446744073709551515;
  localparam logic [VarW-1:0] Absent = VarW'(VarCount);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_BUMP   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;
endpackage
`default_nettype wire

/* src/activity_priority_heap_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// activity_priority_heap_unit
// Indexed binary max-heap of variables keyed by a 64-bit activity score.
// ----------------------------------------------------------------------------
// Insert and bump climb the heap level by level and pop descends it; a bump that
// overflows first walks the 128 scores and halves each one.
// Throughput: one word at a time; busy is high from the accepting edge until done.
// Reset: a pass over all entries zeroes the scores and marks every variable absent.
module activity_priority_heap_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             action,
  input  wire logic [7:0]             item_var,
  input  wire logic [15:0]            bump_amount,
  output logic                        done,
  output logic [7:0]                  popped_var,
  output logic                        heap_is_empty,
  output logic                        var_present,
  output logic                        scores_halved
);
  import aph_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_BUMP_RD, S_BUMP_W, S_HALF_RD, S_HALF_W,
    S_UP_START, S_UP_PSLOT, S_UP_PSC, S_UP_CMP,
    S_POP_TOP, S_POP_LAST, S_POP_SET, S_DN_L, S_DN_LSC, S_DN_R, S_DN_RSC,
    S_DN_CMP, S_PLACE, S_DONE, S_RESULT
  } state_t;

  // Memories: one access per cycle each, registered read data.
  logic [63:0]     score_mem [0:VarCount];
  logic [VarW-1:0] slot_mem  [0:VarCount];
  logic [VarW-1:0] heap_mem  [0:VarCount-1];

  logic [63:0]     score_rd;
  logic [VarW-1:0] slot_rd;
  logic [VarW-1:0] heap_rd;

  logic            sc_we, sl_we, hp_we;
  logic [VarW-1:0] sc_addr, sl_addr;
  logic [SlotW-1:0] hp_addr;
  logic [63:0]     sc_wd;
  logic [VarW-1:0] sl_wd, hp_wd;

  always_ff @(posedge clk) begin
    if (sc_we) score_mem[sc_addr] <= sc_wd;
    score_rd <= score_mem[sc_addr];
  end
  always_ff @(posedge clk) begin
    if (sl_we) slot_mem[sl_addr] <= sl_wd;
    slot_rd <= slot_mem[sl_addr];
  end
  always_ff @(posedge clk) begin
    if (hp_we) heap_mem[hp_addr] <= hp_wd;
    heap_rd <= heap_mem[hp_addr];
  end

  state_t          state;
  logic [1:0]      act;
  logic [VarW-1:0] v;
  logic [15:0]     amt;
  logic [CntW-1:0] count;
  logic [VarW-1:0] idx;       // clear / halving index
  logic [VarW-1:0] x;         // moving variable
  logic [63:0]     xs;        // its score
  logic [SlotW-1:0] pos;      // current slot of the hole
  logic [SlotW-1:0] cslot;    // candidate slot
  logic [VarW-1:0] cvar, lvar, rvar;
  logic [63:0]     csc, lsc;
  logic [VarW-1:0] top;
  logic            halved;

  logic v_ok;
  assign v_ok = (v != '0) && (v <= VarW'(VarCount));

  logic [CntW:0] lchild, rchild;
  assign lchild = {pos, 1'b1} + (CntW+1)'(0);
  assign rchild = lchild + 1'b1;

  always_comb begin
    sc_we = 1'b0; sl_we = 1'b0; hp_we = 1'b0;
    sc_addr = v; sl_addr = v; hp_addr = pos;
    sc_wd = '0; sl_wd = '0; hp_wd = '0;
    unique case (state)
      S_CLEAR: begin
        sc_we = 1'b1; sl_we = 1'b1; sc_addr = idx; sl_addr = idx;
        sl_wd = Absent;
      end
      S_IDLE: begin
        sc_addr = item_var; sl_addr = item_var; hp_addr = '0;
      end
      S_BUMP_W: begin
        sc_we = 1'b1; sc_wd = xs;
      end
      S_HALF_RD: sc_addr = idx;
      S_HALF_W: begin
        sc_we = 1'b1; sc_addr = idx; sc_wd = {1'b0, score_rd[63:1]};
      end
      S_UP_START: sc_addr = x;
      S_UP_PSLOT: hp_addr = SlotW'((pos - 1'b1) >> 1);
      S_UP_PSC: sc_addr = heap_rd;
      S_UP_CMP: begin
        if (score_rd < xs) begin
          hp_we = 1'b1; hp_addr = pos; hp_wd = cvar;
          sl_we = 1'b1; sl_addr = cvar; sl_wd = VarW'(pos);
        end
      end
      S_POP_TOP: begin
        hp_addr = SlotW'(count - 1'b1);
      end
      S_POP_LAST: begin
        // Fetch the score of the last entry, which moves to the root.
        sl_we = 1'b1; sl_addr = top; sl_wd = Absent;
        sc_addr = heap_rd;
      end
      S_DN_L: hp_addr = SlotW'(lchild);
      S_DN_LSC: begin
        sc_addr = heap_rd; hp_addr = SlotW'(rchild);
      end
      S_DN_R: begin
        if (rchild < (CntW+1)'(count)) sc_addr = heap_rd;
      end
      S_DN_CMP: begin
        if (!(xs > csc)) begin
          hp_we = 1'b1; hp_addr = pos; hp_wd = cvar;
          sl_we = 1'b1; sl_addr = cvar; sl_wd = VarW'(pos);
        end
      end
      S_PLACE: begin
        hp_we = 1'b1; hp_addr = pos; hp_wd = x;
        sl_we = 1'b1; sl_addr = x; sl_wd = VarW'(pos);
      end
      S_DONE: sl_addr = v;
      default: ;
    endcase
  end

  logic [64:0] sum;
  assign sum = {1'b0, score_rd} + 65'(amt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; idx <= '0; count <= '0; done <= 1'b0; busy <= 1'b1;
      popped_var <= '0; heap_is_empty <= 1'b1; var_present <= 1'b0;
      scores_halved <= 1'b0;
    end else begin
      done <= (state == S_RESULT);
      unique case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == VarW'(VarCount)) begin
            state <= S_IDLE; busy <= 1'b0;
          end
        end
        S_IDLE: if (start) begin
          busy <= 1'b1; act <= action; v <= item_var; amt <= bump_amount;
          halved <= 1'b0; top <= '0;
          unique case (action_t'(action))
            ACT_INSERT: state <= S_BUMP_RD;
            ACT_POP:    state <= S_POP_TOP;
            ACT_BUMP:   state <= S_BUMP_RD;
            default:    state <= S_DONE;
          endcase
        end
        S_BUMP_RD: begin
          // score_rd and slot_rd hold the variable's entries now.
          if (!v_ok) state <= S_DONE;
          else if (action_t'(act) == ACT_INSERT) begin
            if (slot_rd != Absent || count == CntW'(VarCount)) state <= S_DONE;
            else begin
              x <= v; xs <= score_rd; pos <= SlotW'(count);
              count <= count + 1'b1; state <= S_UP_START;
            end
          end else if (score_rd > ScoreLimit - 64'(amt)) begin
            halved <= 1'b1; idx <= VarW'(1); state <= S_HALF_RD;
          end else begin
            xs <= sum[63:0]; state <= S_BUMP_W;
          end
        end
        S_HALF_RD: state <= S_HALF_W;
        S_HALF_W: begin
          if (idx == VarW'(VarCount)) state <= S_BUMP_W;
          else state <= S_HALF_RD;
          if (idx == v) xs <= {1'b0, score_rd[63:1]} + 64'(amt >> 1);
          idx <= idx + 1'b1;
        end
        S_BUMP_W: begin
          if (slot_rd != Absent) begin
            x <= v; pos <= SlotW'(slot_rd); state <= S_UP_START;
          end else state <= S_DONE;
        end
        S_UP_START: begin
          if (pos == '0) state <= S_PLACE;
          else state <= S_UP_PSLOT;
        end
        S_UP_PSLOT: state <= S_UP_PSC;
        S_UP_PSC: begin
          cvar <= heap_rd; state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (score_rd < xs) begin
            pos <= SlotW'((pos - 1'b1) >> 1); state <= S_UP_START;
          end else state <= S_PLACE;
        end
        S_POP_TOP: begin
          if (count == '0) state <= S_DONE;
          else begin
            top <= heap_rd; state <= S_POP_LAST;
          end
        end
        S_POP_LAST: begin
          x <= heap_rd; pos <= '0;
          count <= count - 1'b1;
          if (heap_rd == top) state <= S_DONE; // heap held just one entry
          else state <= S_POP_SET;
        end
        S_POP_SET: begin
          xs <= score_rd;
          if (count <= CntW'(1)) state <= S_PLACE;
          else state <= S_DN_L;
        end
        S_DN_L: begin
          if (lchild >= (CntW+1)'(count)) state <= S_PLACE;
          else state <= S_DN_LSC;
        end
        S_DN_LSC: begin
          lvar <= heap_rd; state <= S_DN_R;
        end
        S_DN_R: begin
          // score_rd is the left child's score; heap_rd the right child.
          if (rchild < (CntW+1)'(count)) begin
            rvar <= heap_rd; lsc <= score_rd; state <= S_DN_RSC;
          end else begin
            cvar <= lvar; cslot <= SlotW'(lchild); csc <= score_rd;
            state <= S_DN_CMP;
          end
        end
        S_DN_RSC: begin
          // The right child wins only when strictly larger.
          if (score_rd > lsc) begin
            cvar <= rvar; cslot <= SlotW'(rchild); csc <= score_rd;
          end else begin
            cvar <= lvar; cslot <= SlotW'(lchild); csc <= lsc;
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (!(xs > csc)) begin
            pos <= cslot; state <= S_DN_L;
          end else state <= S_PLACE;
        end
        S_PLACE: state <= S_DONE;
        S_DONE: state <= S_RESULT;
        S_RESULT: begin
          // slot_rd refers to v, read after every write of this word.
          state <= S_IDLE; busy <= 1'b0;
          popped_var <= top;
          heap_is_empty <= (count == '0);
          var_present <= v_ok && (slot_rd != Absent);
          scores_halved <= halved;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CntW'(VarCount)))
    else $error("count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start not taken");
endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Activity heap testbench
// Drives insert, pop, bump and idle words into the heap unit and keeps its own
// copy of the scores and heap order. Every result is checked field by field
// against the predicted word for the oldest accepted command.
// ----------------------------------------------------------------------------
module tb;
  import aph_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 400;

  typedef struct packed {
    logic [7:0] popped_var;
    logic       heap_is_empty;
    logic       var_present;
    logic       scores_halved;
  } heap_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = ACT_NOP;
  logic [7:0]  item_var = '0;
  logic [15:0] bump_amount = '0;
  logic        busy, done;
  logic [7:0]  popped_var;
  logic        heap_is_empty, var_present, scores_halved;

  activity_priority_heap_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .item_var(item_var), .bump_amount(bump_amount), .done(done),
    .popped_var(popped_var), .heap_is_empty(heap_is_empty),
    .var_present(var_present), .scores_halved(scores_halved)
  );

  always #5 clk = ~clk;

  // Shadow copy of the heap state, kept in step with every accepted word.
  logic [63:0] score_tbl [0:VarCount];
  logic [7:0]  heap_tbl  [0:VarCount-1];
  logic [7:0]  slot_tbl  [0:VarCount];
  int          heap_size;

  heap_result_t pending_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic bit var_ok(logic [7:0] v);
    return v >= 1 && v <= VarCount;
  endfunction

  // Ties leave the climbing entry where it is: only a strictly larger score
  // moves it past its parent.
  function automatic void climb(int i);
    logic [7:0] x;
    int p;
    x = heap_tbl[i];
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(score_tbl[x] > score_tbl[heap_tbl[p]])) break;
      heap_tbl[i] = heap_tbl[p];
      slot_tbl[heap_tbl[p]] = 8'(i);
      i = p;
    end
    heap_tbl[i] = x;
    slot_tbl[x] = 8'(i);
  endfunction

  // The right child is taken only when strictly larger than the left one, and
  // the sinking entry stops only when strictly larger than that child.
  function automatic void sink(int i);
    logic [7:0] x;
    int l, c;
    x = heap_tbl[i];
    forever begin
      l = 2 * i + 1;
      if (l >= heap_size) break;
      c = l;
      if (l + 1 < heap_size && score_tbl[heap_tbl[l + 1]] > score_tbl[heap_tbl[l]])
        c = l + 1;
      if (score_tbl[x] > score_tbl[heap_tbl[c]]) break;
      heap_tbl[i] = heap_tbl[c];
      slot_tbl[heap_tbl[i]] = 8'(i);
      i = c;
    end
    heap_tbl[i] = x;
    slot_tbl[x] = 8'(i);
  endfunction

  function automatic heap_result_t apply_heap_word(action_t act, logic [7:0] v,
                                                   logic [15:0] amt);
    heap_result_t r;
    logic [7:0] top;
    r = '0;
    case (act)
      ACT_INSERT: begin
        if (var_ok(v) && slot_tbl[v] == Absent && heap_size < VarCount) begin
          heap_tbl[heap_size] = v;
          slot_tbl[v] = 8'(heap_size);
          heap_size++;
          climb(heap_size - 1);
        end
      end
      ACT_POP: begin
        if (heap_size > 0) begin
          top = heap_tbl[0];
          heap_tbl[0] = heap_tbl[heap_size - 1];
          slot_tbl[heap_tbl[0]] = 8'd0;
          slot_tbl[top] = Absent;
          heap_size--;
          if (heap_size > 1) sink(0);
          r.popped_var = top;
        end
      end
      ACT_BUMP: begin
        if (var_ok(v)) begin
          // The limit test subtracts first, so the sum itself never wraps.
          if (score_tbl[v] > ScoreLimit - 64'(amt)) begin
            for (int i = 1; i <= VarCount; i++) score_tbl[i] = score_tbl[i] >> 1;
            score_tbl[v] = score_tbl[v] + 64'(amt >> 1);
            r.scores_halved = 1'b1;
          end else begin
            score_tbl[v] = score_tbl[v] + 64'(amt);
          end
          if (slot_tbl[v] != Absent) climb(int'(slot_tbl[v]));
        end
      end
      default: ;
    endcase
    r.heap_is_empty = (heap_size == 0);
    r.var_present = var_ok(v) && slot_tbl[v] != Absent;
    return r;
  endfunction

  // Sends one word, entered and left at a falling edge. The sender idles in
  // bursts: a random run of back-to-back words, then a random gap.
  task automatic send_word(action_t act, logic [7:0] v, logic [15:0] amt);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    start = 1'b1;
    action = act;
    item_var = v;
    bump_amount = amt;
    // busy only moves at a rising edge, so a low busy here means the next
    // rising edge takes the word.
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(apply_heap_word(act, v, amt));
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [7:0] any_var();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(1, VarCount));
  endfunction

  // Edges of the input fields and special cases such as invalid, repeated and absent variables.
  task automatic test_directed();
    send_word(ACT_POP, 8'd5, 16'd0);       // pop of an empty heap
    send_word(ACT_INSERT, 8'd0, 16'd0);    // invalid variables
    send_word(ACT_INSERT, 8'd129, 16'd0);
    send_word(ACT_BUMP, 8'd255, 16'hffff);
    send_word(ACT_NOP, 8'd7, 16'hffff);
    send_word(ACT_INSERT, 8'd1, 16'd0);
    send_word(ACT_INSERT, 8'd128, 16'd0);
    send_word(ACT_INSERT, 8'd1, 16'd0);    // already present
    send_word(ACT_BUMP, 8'd128, 16'hffff);
    send_word(ACT_BUMP, 8'd64, 16'h5555);  // absent variable
    send_word(ACT_INSERT, 8'd64, 16'haaaa);
    send_word(ACT_BUMP, 8'd1, 16'd0);
    send_word(ACT_NOP, 8'd128, 16'd0);
    repeat (4) send_word(ACT_POP, 8'd0, 16'd0);
  endtask

  // Fill part of the heap with equal and spread scores, then drain it.
  task automatic test_fill_drain();
    for (int i = 0; i < 40; i++) send_word(ACT_INSERT, 8'($urandom_range(1, VarCount)), 16'd0);
    for (int i = 0; i < 10; i++)
      send_word(ACT_BUMP, 8'($urandom_range(1, VarCount)), 16'($urandom_range(0, 3)));
    for (int i = 0; i < 42; i++) send_word(ACT_POP, 8'($urandom), 16'($urandom));
  endtask

  // Mostly valid traffic with the heap kept well populated.
  task automatic test_random_mix();
    int pick;
    for (int i = 0; i < 350; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_word(ACT_INSERT, any_var(), 16'($urandom));
      else if (pick < 60) send_word(ACT_POP, 8'($urandom), 16'($urandom));
      else if (pick < 95) send_word(ACT_BUMP, any_var(), 16'($urandom));
      else send_word(ACT_NOP, 8'($urandom), 16'($urandom));
    end
  endtask

  // Results are sampled at the rising edge; done lasts exactly one cycle.
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (popped_var !== want.popped_var) begin
          $error("popped_var: expected %0d, got %0d", want.popped_var, popped_var);
          fail_count++;
        end
        if (heap_is_empty !== want.heap_is_empty) begin
          $error("heap_is_empty: expected %0b, got %0b", want.heap_is_empty, heap_is_empty);
          fail_count++;
        end
        if (var_present !== want.var_present) begin
          $error("var_present: expected %0b, got %0b", want.var_present, var_present);
          fail_count++;
        end
        if (scores_halved !== want.scores_halved) begin
          $error("scores_halved: expected %0b, got %0b", want.scores_halved, scores_halved);
          fail_count++;
        end
      end
    end
  end

  // The watchdog counts cycles in which no word goes in and none comes out.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= VarCount; i++) begin
      score_tbl[i] = '0;
      slot_tbl[i] = Absent;
    end
    heap_size = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_drain();
    test_random_mix();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
src/aph_pkg.sv
src/activity_priority_heap_unit.sv
bench/tb.sv
